// ----- design/assert_macros.svh -----
// Assertion shorthands for the event scheduler.
// Used by delta_event_scheduler; clock i_clk, reset i_rst_n assumed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define DSCH_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define DSCH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSCH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dsch_pkg.sv -----
// Shared types and constants for the event scheduler.
// No dependencies.
package dsch_pkg;

    localparam int TIME_BITS  = 32;
    localparam int TICKS_BITS = 31;

    typedef logic [TIME_BITS-1:0] t_time;

    // op codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ENQ  = 1'b1;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Biased key: signed distance from now, compared as unsigned.
    localparam t_time KEY_BIAS   = 32'h8000_0000;
    // An event is due when its biased key is below this value.
    localparam t_time FIRE_LIMIT = 32'h8000_0001;

    typedef struct packed {
        logic fired;
        logic status;
        logic last;
    } t_result;

endpackage

// ----- design/delta_event_scheduler.sv -----
// Event scheduler: min-heap of deadlines in one RAM; needs dsch_pkg and assert_macros.svh.
// Enqueue: a full heap goes straight to the result word; otherwise the entry climbs levels
// toward the root until it reaches it or a compare stops it. Tick: advance time, then remove
// each due root and sift the tail entry down until the root is not due or the heap is empty.
// One word at a time: input stalls until the result word is handed over; output back-pressure
// can hold the sequencer. Reset (sync, i_rst_n low): time 0, heap empty, RAM kept.
`include "assert_macros.svh"

module delta_event_scheduler #(
    parameter int QUEUE_DEPTH = 64,
    parameter int CODE_BITS   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [30:0]                i_ticks,
    input  logic [CODE_BITS-1:0]       i_event_code,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_event_fired,
    output logic [CODE_BITS-1:0]       o_fired_code,
    output logic                       o_status,
    output logic                       o_last
);
    import dsch_pkg::*;

    // ------------------------------------------------------------------
    // Sizes
    // ------------------------------------------------------------------
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1; // heap index
    localparam int CW = $clog2(QUEUE_DEPTH + 1);                      // entry count
    localparam int XW = IW + 2;                                       // child index math
    localparam int EW = TIME_BITS + CODE_BITS;                        // {deadline, code}

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ENQ     = 4'd1;   // full check, deadline = now + delay
    localparam logic [3:0] S_UP_RD   = 4'd2;   // sift-up: fetch parent
    localparam logic [3:0] S_UP_CMP  = 4'd3;   // sift-up: compare, move parent down
    localparam logic [3:0] S_TICK    = 4'd4;   // advance time
    localparam logic [3:0] S_POP_RD  = 4'd5;   // fetch root
    localparam logic [3:0] S_POP_CHK = 4'd6;   // root due? emit previous, start removal
    localparam logic [3:0] S_DN_LAST = 4'd7;   // tail entry arrives, becomes the mover
    localparam logic [3:0] S_DN_RD   = 4'd8;   // sift-down: fetch left child
    localparam logic [3:0] S_DN_C0   = 4'd9;   // left child key, fetch right child
    localparam logic [3:0] S_DN_C1   = 4'd10;  // pick smaller child
    localparam logic [3:0] S_DN_DEC  = 4'd11;  // mover vs child: stop or move child up
    localparam logic [3:0] S_RESULT  = 4'd12;  // hand final word to output register

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]           r_state,    n_state;
    t_time                r_time,     n_time;
    logic [CW-1:0]        r_cnt,      n_cnt;
    logic [IW-1:0]        r_idx,      n_idx;      // current hole in the heap
    logic [IW-1:0]        r_par,      n_par;
    logic [XW-1:0]        r_child,    n_child;
    logic [TICKS_BITS-1:0] r_ticks,   n_ticks;
    logic [CODE_BITS-1:0] r_code,     n_code;
    logic [EW-1:0]        r_ins,      n_ins;      // entry being sifted
    t_time                r_ins_key,  n_ins_key;
    logic [EW-1:0]        r_best,     n_best;     // smaller child
    t_time                r_best_key, n_best_key;
    logic [IW-1:0]        r_best_idx, n_best_idx;
    logic                 r_have,     n_have;     // a fired event awaits emission
    logic [CODE_BITS-1:0] r_pend,     n_pend;
    t_result              r_res,      n_res;      // final word of this item
    logic [CODE_BITS-1:0] r_res_code, n_res_code;

    // output register
    logic                 r_out_valid;
    t_result              r_out;
    logic [CODE_BITS-1:0] r_out_code;

    // heap RAM: one write port, one registered read port
    logic [EW-1:0]        r_mem [QUEUE_DEPTH];
    logic [EW-1:0]        r_rd;
    logic                 mem_we;
    logic [IW-1:0]        mem_wa;
    logic [EW-1:0]        mem_wd;
    logic [IW-1:0]        mem_ra;

    // shared adder and comparator
    t_time                add_a, add_b, add_sum;
    logic                 add_cin;
    t_time                key_k;
    t_time                cmp_a, cmp_b;
    logic                 cmp_lt;

    // output loading
    logic                 out_free;
    logic                 out_load;
    t_result              out_res;
    logic [CODE_BITS-1:0] out_code;

    // index helpers
    logic [XW-1:0]        cnt_x;
    logic [XW-1:0]        child_l;
    logic [XW-1:0]        child_r;
    logic [IW-1:0]        parent;
    logic [CW-1:0]        cnt_dec;
    t_time                rd_dl;
    logic [CODE_BITS-1:0] rd_code;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign rd_dl   = r_rd[EW-1:CODE_BITS];
    assign rd_code = r_rd[CODE_BITS-1:0];

    // One 32-bit adder: now + delay, or deadline - now (two's complement).
    assign add_sum = add_a + add_b + TIME_BITS'(add_cin);
    assign key_k   = add_sum ^ KEY_BIAS;
    assign cmp_lt  = (cmp_a < cmp_b);

    assign cnt_x   = XW'(r_cnt);
    assign child_l = XW'({r_idx, 1'b1});
    assign child_r = r_child + XW'(1);
    assign parent  = (r_idx - IW'(1)) >> 1;
    assign cnt_dec = r_cnt - CW'(1);

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_time     = r_time;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_par      = r_par;
        n_child    = r_child;
        n_ticks    = r_ticks;
        n_code     = r_code;
        n_ins      = r_ins;
        n_ins_key  = r_ins_key;
        n_best     = r_best;
        n_best_key = r_best_key;
        n_best_idx = r_best_idx;
        n_have     = r_have;
        n_pend     = r_pend;
        n_res      = r_res;
        n_res_code = r_res_code;

        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_wd  = r_ins;
        mem_ra  = '0;

        // adder defaults to key mode
        add_a   = rd_dl;
        add_b   = ~r_time;
        add_cin = 1'b1;
        cmp_a   = key_k;
        cmp_b   = r_ins_key;

        out_load = 1'b0;
        out_res  = r_res;
        out_code = r_res_code;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ticks = i_ticks;
                    n_code  = i_event_code;
                    n_have  = 1'b0;
                    n_state = (i_op == OP_ENQ) ? S_ENQ : S_TICK;
                end
            end

            S_ENQ: begin
                add_a   = r_time;
                add_b   = TIME_BITS'(r_ticks);
                add_cin = 1'b0;
                n_res      = '{fired: 1'b0, status: ST_OK, last: 1'b1};
                n_res_code = '0;
                if (r_cnt == CW'(QUEUE_DEPTH)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_RESULT;
                end else begin
                    n_ins     = {add_sum, r_code};
                    // deadline - now is the delay itself
                    n_ins_key = TIME_BITS'(r_ticks) ^ KEY_BIAS;
                    n_idx     = r_cnt[IW-1:0];
                    n_cnt     = r_cnt + CW'(1);
                    n_state   = S_UP_RD;
                end
            end

            S_UP_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    mem_ra  = parent;
                    n_par   = parent;
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                cmp_a = r_ins_key;
                cmp_b = key_k;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wd  = r_rd;
                    n_idx   = r_par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_RESULT;
                end
            end

            S_TICK: begin
                add_a   = r_time;
                add_b   = TIME_BITS'(r_ticks);
                add_cin = 1'b0;
                n_time  = add_sum;
                n_state = S_POP_RD;
            end

            S_POP_RD: begin
                if (r_cnt == '0) begin
                    n_res      = '{fired: r_have, status: ST_OK, last: 1'b1};
                    n_res_code = r_have ? r_pend : '0;
                    n_state    = S_RESULT;
                end else begin
                    mem_ra  = '0;
                    n_state = S_POP_CHK;
                end
            end

            S_POP_CHK: begin
                cmp_a = key_k;
                cmp_b = FIRE_LIMIT;
                if (!cmp_lt) begin
                    // root not due: the pending event, if any, is the last word
                    n_res      = '{fired: r_have, status: ST_OK, last: 1'b1};
                    n_res_code = r_have ? r_pend : '0;
                    n_state    = S_RESULT;
                end else if (r_have && !out_free) begin
                    mem_ra = '0;     // hold root in the read register
                end else begin
                    if (r_have) begin
                        out_load = 1'b1;
                        out_res  = '{fired: 1'b1, status: ST_OK, last: 1'b0};
                        out_code = r_pend;
                    end
                    n_have  = 1'b1;
                    n_pend  = rd_code;
                    n_cnt   = cnt_dec;
                    mem_ra  = cnt_dec[IW-1:0];
                    n_state = S_DN_LAST;
                end
            end

            S_DN_LAST: begin
                if (r_cnt == '0) begin
                    n_state = S_POP_RD;
                end else begin
                    n_ins     = r_rd;
                    n_ins_key = key_k;
                    n_idx     = '0;
                    n_state   = S_DN_RD;
                end
            end

            S_DN_RD: begin
                if (child_l >= cnt_x) begin
                    mem_we  = 1'b1;
                    n_state = S_POP_RD;
                end else begin
                    mem_ra  = child_l[IW-1:0];
                    n_child = child_l;
                    n_state = S_DN_C0;
                end
            end

            S_DN_C0: begin
                n_best     = r_rd;
                n_best_key = key_k;
                n_best_idx = r_child[IW-1:0];
                if (child_r < cnt_x) begin
                    mem_ra  = child_r[IW-1:0];
                    n_state = S_DN_C1;
                end else begin
                    n_state = S_DN_DEC;
                end
            end

            S_DN_C1: begin
                cmp_a = key_k;
                cmp_b = r_best_key;
                if (cmp_lt) begin
                    n_best     = r_rd;
                    n_best_key = key_k;
                    n_best_idx = child_r[IW-1:0];
                end
                n_state = S_DN_DEC;
            end

            S_DN_DEC: begin
                cmp_a  = r_best_key;
                cmp_b  = r_ins_key;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wd  = r_best;
                    n_idx   = r_best_idx;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_POP_RD;
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Register updates
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_cnt       <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
            r_cnt   <= n_cnt;
            r_have  <= n_have;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_par      <= n_par;
        r_child    <= n_child;
        r_ticks    <= n_ticks;
        r_code     <= n_code;
        r_ins      <= n_ins;
        r_ins_key  <= n_ins_key;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_best_idx <= n_best_idx;
        r_pend     <= n_pend;
        r_res      <= n_res;
        r_res_code <= n_res_code;
        if (out_load) begin
            r_out      <= out_res;
            r_out_code <= out_code;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_event_fired = r_out.fired;
    assign o_fired_code  = r_out_code;
    assign o_status      = r_out.status;
    assign o_last        = r_out.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DSCH_ASSERT_NOW(a_cnt_range, r_cnt <= CW'(QUEUE_DEPTH), "entry count above depth")
    `DSCH_ASSERT_IMP(a_out_free, out_load, !r_out_valid || !i_stall, "output word overwritten")
    `DSCH_ASSERT_NXT(a_time_hold, r_state != S_TICK, $stable(r_time), "time moved outside tick")
    `DSCH_ASSERT_NXT(a_cnt_inc, (r_state == S_ENQ) && (r_cnt != CW'(QUEUE_DEPTH)),
        r_cnt == $past(r_cnt) + CW'(1), "enqueue did not grow the heap")

endmodule
